>>> hw/rtl/ybpp_pkg.sv
// Package with payload types, coefficients and the byte clamp for the YUV to BGR pair converter.
package ybpp_pkg;

  // Fixed-point coefficients, scaled by 128; OffsetR and OffsetB are in whole units.
  localparam int unsigned CoefY     = 149;
  localparam int unsigned CoefVR    = 204;
  localparam int unsigned CoefUG    = 50;
  localparam int unsigned CoefVG    = 104;
  localparam int unsigned OffsetR   = 223;
  localparam int unsigned OffsetG   = 135 * 128;
  localparam int unsigned OffsetB   = 277;
  localparam int unsigned RoundHalf = 64;
  localparam int unsigned FracBits  = 7;

  // Width of the signed intermediate sums.
  localparam int unsigned SumW = 18;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] luma_second;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
  } ybpp_in_t;

  typedef struct packed {
    logic [7:0] blue_first;
    logic [7:0] green_first;
    logic [7:0] red_first;
    logic [7:0] blue_second;
    logic [7:0] green_second;
    logic [7:0] red_second;
  } ybpp_out_t;

  // Saturates a signed sum to the range 0..255.
  function automatic logic [7:0] clamp_byte(logic signed [SumW-1:0] x);
    logic [7:0] res;
    if (x[SumW-1]) begin
      res = 8'd0;
    end else if (x > $signed(SumW'(255))) begin
      res = 8'd255;
    end else begin
      res = x[7:0];
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/yuv_to_bgr_pixel_pair_core.sv
// Top level of the YUV to BGR pixel pair converter: input register, conversion, result register.
//
// Usage: the upstream source presents a pixel pair (two luma samples and the
// shared U and V samples) on in_data_i with in_valid_i. A transaction on the
// input channel happens when in_valid_i and in_ready_o are both high. The
// converted pair, two BGR pixels clamped to 0..255, leaves on out_data_o with
// out_valid_o and is taken when out_ready_i is high.
// The pair is captured in the input register, and then the converted result is
// captured in the result register and shown on the output channel.
// Throughput is one pair per clock cycle while the receiver does not stall, set by
// the two-stage pipeline with a single short arithmetic pass (constant multiplies,
// adds and a clamp) between the input register and the result register.
// When the receiver stalls, the result register holds its transaction and the
// input register can still take one more pair; only when both are full does
// in_ready_o fall. Ready propagates combinationally back from out_ready_i.
// Reset clears both valid flags, so the block comes up empty and ready; the
// payload registers are not reset.
module yuv_to_bgr_pixel_pair_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ybpp_pkg::ybpp_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ybpp_pkg::ybpp_out_t out_data_o
);
  import ybpp_pkg::*;

  // Input stage.
  logic      in_valid_q;
  logic      in_valid_d;
  ybpp_in_t  in_data_q;

  // Result stage.
  logic      out_valid_q;
  logic      out_valid_d;
  ybpp_out_t out_data_q;
  ybpp_out_t out_data_d;

  logic      result_ready;
  logic      in_fire;
  logic      advance;

  // The result register can take a new transaction when it is empty or is
  // being drained in this cycle.
  assign result_ready = !out_valid_q || out_ready_i;
  assign advance      = in_valid_q && result_ready;
  assign in_ready_o   = !in_valid_q || result_ready;
  assign in_fire      = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  // Both pixels share the chroma samples; each gets its own converter.
  ybpp_pixel_conv u_conv_first (
    .luma_i        (in_data_q.luma_first),
    .chroma_blue_i (in_data_q.chroma_blue),
    .chroma_red_i  (in_data_q.chroma_red),
    .blue_o        (out_data_d.blue_first),
    .green_o       (out_data_d.green_first),
    .red_o         (out_data_d.red_first)
  );

  ybpp_pixel_conv u_conv_second (
    .luma_i        (in_data_q.luma_second),
    .chroma_blue_i (in_data_q.chroma_blue),
    .chroma_red_i  (in_data_q.chroma_red),
    .blue_o        (out_data_d.blue_second),
    .green_o       (out_data_d.green_second),
    .red_o         (out_data_d.red_second)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // An empty input stage must always be able to take a transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !in_valid_q |-> in_ready_o)
    else $error("input stage empty but not ready");

  // An accepted pair is held in the input stage on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_fire |=> in_valid_q)
    else $error("accepted pair lost from input stage");

  // A pair that moves on always appears as a valid result.
  assert property (@(posedge clk_i) disable iff (!rst_ni) advance |=> out_valid_q)
    else $error("converted pair not presented");

  // A pair blocked by a stalled result stays in the input stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (in_valid_q && !result_ready) |=> in_valid_q)
    else $error("blocked pair dropped from input stage");
`endif

endmodule

>>> hw/rtl/ybpp_pixel_conv.sv
// Combinational BT.601 conversion of one pixel from Y, U and V to clamped B, G and R.
module ybpp_pixel_conv (
  input  logic [7:0] luma_i,
  input  logic [7:0] chroma_blue_i,
  input  logic [7:0] chroma_red_i,
  output logic [7:0] blue_o,
  output logic [7:0] green_o,
  output logic [7:0] red_o
);
  import ybpp_pkg::*;

  logic        [15:0]     luma_prod;
  logic        [15:0]     red_prod;
  logic        [8:0]      luma_term;
  logic        [8:0]      red_term;
  logic signed [10:0]     red_sum;
  logic signed [10:0]     blue_sum;
  logic signed [SumW-1:0] green_sum;
  logic signed [SumW-1:0] green_shift;

  assign luma_prod = 16'(luma_i) * 16'(CoefY);
  assign red_prod  = 16'(chroma_red_i) * 16'(CoefVR);

  // Both products stay below 2^16 even after the rounding half is added.
  assign luma_term = 9'((luma_prod + 16'(RoundHalf)) >> FracBits);
  assign red_term  = 9'((red_prod + 16'(RoundHalf)) >> FracBits);

  assign red_sum  = $signed({2'b00, luma_term}) + $signed({2'b00, red_term})
                  - $signed(11'(OffsetR));
  assign blue_sum = $signed({2'b00, luma_term}) + $signed({2'b00, chroma_blue_i, 1'b0})
                  - $signed(11'(OffsetB));

  // Green is kept signed so that a negative sum saturates at zero.
  assign green_sum = $signed({2'b00, luma_prod})
                   + $signed(SumW'(OffsetG + RoundHalf))
                   - $signed(SumW'(chroma_blue_i) * SumW'(CoefUG))
                   - $signed(SumW'(chroma_red_i) * SumW'(CoefVG));
  assign green_shift = green_sum >>> FracBits;

  assign blue_o  = clamp_byte(SumW'(blue_sum));
  assign green_o = clamp_byte(green_shift);
  assign red_o   = clamp_byte(SumW'(red_sum));

endmodule
